### design/lswr_pkg.sv
// Shared types and constants for the LIFO stack with remove-by-id.
`default_nettype none

package lswr_pkg;

    // Stack geometry
    localparam int STACK_DEPTH = 64;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

    // Field widths fixed by the interface
    localparam int ID_W    = 16;
    localparam int HND_W   = 16;
    localparam int OCNT_W  = 7;

    typedef enum logic [1:0] {
        OP_PUSH   = 2'd0,
        OP_POP    = 2'd1,
        OP_REMOVE = 2'd2,
        OP_PEEK   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_RESULT
    } t_state;

    // Whole-row moves of the cell array
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_PUSH,
        CELL_POP,
        CELL_ROTATE
    } t_cell_op;

    typedef struct packed {
        logic     latch_in;
        t_cell_op cell_op;
        logic     capture_got;
        logic     clear_got;
        logic     load_steps;
        logic     dec_steps;
        logic     load_out;
        t_status  out_status;
    } t_dp_cmd;

    typedef struct packed {
        t_op  op;
        logic empty;
        logic full;
        logic top_match;
        logic steps_zero;
    } t_dp_stat;

endpackage

`default_nettype wire

### design/lswr_ctrl.sv
// Controller state machine for the LIFO stack with remove-by-id.
`default_nettype none

module lswr_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire logic              i_out_ready,
    output logic                   o_out_valid,
    input  wire lswr_pkg::t_dp_stat i_stat,
    output lswr_pkg::t_dp_cmd       o_cmd
);
    import lswr_pkg::*;

    t_state  r_state, n_state;
    t_status r_status, n_status;
    logic    r_out_valid;
    logic    w_out_free;

    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_EXEC;
            end
            S_EXEC: begin
                if (i_stat.op == OP_REMOVE && !i_stat.empty) n_state = S_SCAN;
                else n_state = S_RESULT;
            end
            S_SCAN: begin
                if (i_stat.steps_zero) n_state = S_RESULT;
            end
            S_RESULT: begin
                if (w_out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs and status code
    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.cell_op    = CELL_HOLD;
        o_cmd.out_status = r_status;
        n_status   = r_status;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready     = 1'b1;
                o_cmd.latch_in = i_in_valid;
            end
            S_EXEC: begin
                o_cmd.clear_got = 1'b1;
                unique case (i_stat.op)
                    OP_PUSH: begin
                        if (i_stat.full) begin
                            n_status = ST_FULL;
                        end else begin
                            n_status      = ST_OK;
                            o_cmd.cell_op = CELL_PUSH;
                        end
                    end
                    OP_POP: begin
                        if (i_stat.empty) begin
                            n_status = ST_EMPTY;
                        end else begin
                            n_status          = ST_OK;
                            o_cmd.cell_op     = CELL_POP;
                            o_cmd.capture_got = 1'b1;
                            o_cmd.clear_got   = 1'b0;
                        end
                    end
                    OP_REMOVE: begin
                        // not-found until the walk drops a match
                        if (i_stat.empty) begin
                            n_status = ST_EMPTY;
                        end else begin
                            n_status         = ST_NOT_FOUND;
                            o_cmd.load_steps = 1'b1;
                        end
                    end
                    OP_PEEK: begin
                        n_status = i_stat.empty ? ST_EMPTY : ST_OK;
                    end
                    default: n_status = ST_OK;
                endcase
            end
            S_SCAN: begin
                // one original entry reaches the top each cycle
                if (!i_stat.steps_zero) begin
                    o_cmd.dec_steps = 1'b1;
                    if (r_status == ST_NOT_FOUND && i_stat.top_match) begin
                        n_status          = ST_OK;
                        o_cmd.cell_op     = CELL_POP;
                        o_cmd.capture_got = 1'b1;
                    end else begin
                        o_cmd.cell_op = CELL_ROTATE;
                    end
                end
            end
            S_RESULT: begin
                o_cmd.load_out = w_out_free;
            end
            default: ;
        endcase
    end

    // Status code for the beat in flight
    always_ff @(posedge i_clk) begin
        r_status <= n_status;
    end

    // Output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

endmodule

`default_nettype wire

### design/lswr_dpath.sv
// Datapath: row of stack cells (top at cell 0), counters and result register.
`default_nettype none

module lswr_dpath (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic [1:0]                   i_operation,
    input  wire logic [lswr_pkg::ID_W-1:0]    i_item_id,
    input  wire logic [lswr_pkg::HND_W-1:0]   i_item_handle,
    input  wire lswr_pkg::t_dp_cmd            i_cmd,
    output lswr_pkg::t_dp_stat                o_stat,
    output logic [1:0]                        o_status,
    output logic [lswr_pkg::ID_W-1:0]         o_out_id,
    output logic [lswr_pkg::HND_W-1:0]        o_out_handle,
    output logic [lswr_pkg::ID_W-1:0]         o_top_id,
    output logic [lswr_pkg::HND_W-1:0]        o_top_handle,
    output logic [lswr_pkg::OCNT_W-1:0]       o_entry_count,
    output logic                              o_is_empty
);
    import lswr_pkg::*;

    // Cells and their lower neighbours
    logic [ID_W-1:0]  r_ids  [STACK_DEPTH];
    logic [HND_W-1:0] r_hnds [STACK_DEPTH];
    logic [ID_W-1:0]  w_next_id  [STACK_DEPTH];
    logic [HND_W-1:0] w_next_hnd [STACK_DEPTH];

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] r_steps;
    t_op              r_op;
    logic [ID_W-1:0]  r_key;
    logic [HND_W-1:0] r_hnd;
    logic [ID_W-1:0]  r_got_id;
    logic [HND_W-1:0] r_got_hnd;
    logic             w_empty;

    // Result register
    t_status            r_out_status;
    logic [ID_W-1:0]    r_out_id;
    logic [HND_W-1:0]   r_out_hnd;
    logic [ID_W-1:0]    r_top_id;
    logic [HND_W-1:0]   r_top_hnd;
    logic [CNT_W-1:0]   r_out_count;
    logic               r_out_empty;

    assign w_empty = (r_count == '0);

    // Neighbour one step below; bottom cell sees itself
    for (genvar g = 0; g < STACK_DEPTH; g++) begin : g_nb
        if (g < STACK_DEPTH - 1) begin : g_mid
            assign w_next_id[g]  = r_ids[g+1];
            assign w_next_hnd[g] = r_hnds[g+1];
        end else begin : g_bot
            assign w_next_id[g]  = r_ids[g];
            assign w_next_hnd[g] = r_hnds[g];
        end
    end

    // Cell row moves
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.cell_op)
            CELL_PUSH: begin
                r_ids[0]  <= r_key;
                r_hnds[0] <= r_hnd;
                for (int k = 1; k < STACK_DEPTH; k++) begin
                    r_ids[k]  <= r_ids[k-1];
                    r_hnds[k] <= r_hnds[k-1];
                end
            end
            CELL_POP: begin
                for (int k = 0; k < STACK_DEPTH; k++) begin
                    r_ids[k]  <= w_next_id[k];
                    r_hnds[k] <= w_next_hnd[k];
                end
            end
            CELL_ROTATE: begin
                // top entry wraps to the lowest occupied cell
                for (int k = 0; k < STACK_DEPTH; k++) begin
                    if (r_count == CNT_W'(k + 1)) begin
                        r_ids[k]  <= r_ids[0];
                        r_hnds[k] <= r_hnds[0];
                    end else begin
                        r_ids[k]  <= w_next_id[k];
                        r_hnds[k] <= w_next_hnd[k];
                    end
                end
            end
            CELL_HOLD: ;
            default: ;
        endcase
    end

    // Fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.cell_op == CELL_PUSH) begin
            r_count <= r_count + 1'b1;
        end else if (i_cmd.cell_op == CELL_POP) begin
            r_count <= r_count - 1'b1;
        end
    end

    // Walk step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_steps <= '0;
        end else if (i_cmd.load_steps) begin
            r_steps <= r_count;
        end else if (i_cmd.dec_steps) begin
            r_steps <= r_steps - 1'b1;
        end
    end

    // Input beat latch
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_op  <= t_op'(i_operation);
            r_key <= i_item_id;
            r_hnd <= i_item_handle;
        end
    end

    // Entry taken out
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture_got) begin
            r_got_id  <= r_ids[0];
            r_got_hnd <= r_hnds[0];
        end else if (i_cmd.clear_got) begin
            r_got_id  <= '0;
            r_got_hnd <= '0;
        end
    end

    // Result register load
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_status <= i_cmd.out_status;
            r_out_id     <= r_got_id;
            r_out_hnd    <= r_got_hnd;
            r_top_id     <= w_empty ? '0 : r_ids[0];
            r_top_hnd    <= w_empty ? '0 : r_hnds[0];
            r_out_count  <= r_count;
            r_out_empty  <= w_empty;
        end
    end

    assign o_stat.op         = r_op;
    assign o_stat.empty      = w_empty;
    assign o_stat.full       = (r_count == CNT_W'(STACK_DEPTH));
    assign o_stat.top_match  = (r_ids[0] == r_key);
    assign o_stat.steps_zero = (r_steps == '0);

    assign o_status      = r_out_status;
    assign o_out_id      = r_out_id;
    assign o_out_handle  = r_out_hnd;
    assign o_top_id      = r_top_id;
    assign o_top_handle  = r_top_hnd;
    assign o_entry_count = OCNT_W'(r_out_count);
    assign o_is_empty    = r_out_empty;

endmodule

`default_nettype wire

### design/lifo_stack_with_remove_by_key.sv
// Top level of the LIFO stack with remove-by-id.
//
// A bounded LIFO of STACK_DEPTH (id, handle) entries held in a row of register
// cells with the top entry in cell 0. Push, pop and peek go from the execute
// state straight to the result state once the input beat is accepted.
// Remove-by-id walks the stack through the cell row, rotating one entry past
// the top per cycle and dropping the first match it meets, and its walk covers
// every entry held. One operation is in progress at a time; the result
// sits in an output register, so the next beat is accepted while it waits.
// Every result carries the status, the entry taken out (zero if none), the top
// entry after the operation (zero when empty), the entry count and an empty
// flag.
`default_nettype none

module lifo_stack_with_remove_by_key (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    output logic                            o_in_ready,
    input  wire logic [1:0]                 i_operation,
    input  wire logic [lswr_pkg::ID_W-1:0]  i_item_id,
    input  wire logic [lswr_pkg::HND_W-1:0] i_item_handle,
    output logic                            o_out_valid,
    input  wire logic                       i_out_ready,
    output logic [1:0]                      o_status,
    output logic [lswr_pkg::ID_W-1:0]       o_out_id,
    output logic [lswr_pkg::HND_W-1:0]      o_out_handle,
    output logic [lswr_pkg::ID_W-1:0]       o_top_id,
    output logic [lswr_pkg::HND_W-1:0]      o_top_handle,
    output logic [lswr_pkg::OCNT_W-1:0]     o_entry_count,
    output logic                            o_is_empty
);
    import lswr_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    lswr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    lswr_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_operation   (i_operation),
        .i_item_id     (i_item_id),
        .i_item_handle (i_item_handle),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .o_status      (o_status),
        .o_out_id      (o_out_id),
        .o_out_handle  (o_out_handle),
        .o_top_id      (o_top_id),
        .o_top_handle  (o_top_handle),
        .o_entry_count (o_entry_count),
        .o_is_empty    (o_is_empty)
    );

endmodule

`default_nettype wire

### design/lswr_checker.sv
// Port-level checks for the LIFO stack with remove-by-id, and their bind.
`default_nettype none

module lswr_checker (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       o_out_valid,
    input  wire logic                       i_out_ready,
    input  wire logic [1:0]                 o_status,
    input  wire logic [lswr_pkg::ID_W-1:0]  o_out_id,
    input  wire logic [lswr_pkg::HND_W-1:0] o_out_handle,
    input  wire logic [lswr_pkg::ID_W-1:0]  o_top_id,
    input  wire logic [lswr_pkg::HND_W-1:0] o_top_handle,
    input  wire logic [lswr_pkg::OCNT_W-1:0] o_entry_count,
    input  wire logic                       o_is_empty
);
    import lswr_pkg::*;

    // Stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_status)
            && $stable(o_out_id) && $stable(o_top_id) && $stable(o_entry_count))
        else $error("result beat changed while stalled");

    // Empty flag agrees with the count
    a_empty_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_is_empty == (o_entry_count == '0)))
        else $error("empty flag and count disagree");

    // Empty stack shows a zero top entry
    a_empty_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_is_empty |-> (o_top_id == '0) && (o_top_handle == '0))
        else $error("top entry not zero on empty stack");

    // Full status only with a full stack
    a_full_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_FULL) |-> (o_entry_count == OCNT_W'(STACK_DEPTH)))
        else $error("full status with spare room");

    // Empty status leaves nothing taken out
    a_empty_st: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_EMPTY) |-> o_is_empty && (o_out_id == '0)
            && (o_out_handle == '0))
        else $error("empty status with entries or a taken entry");

endmodule

bind lifo_stack_with_remove_by_key lswr_checker u_lswr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_status      (o_status),
    .o_out_id      (o_out_id),
    .o_out_handle  (o_out_handle),
    .o_top_id      (o_top_id),
    .o_top_handle  (o_top_handle),
    .o_entry_count (o_entry_count),
    .o_is_empty    (o_is_empty)
);

`default_nettype wire
